### rtl/assert_macros.svh
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent now, consequent in the next cycle
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// antecedent and consequent in the same cycle
`define SFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/sfd_pkg.sv
// types, constants and helper functions of the stiff string grid stepper
// no dependencies
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int NUM_POINTS = 128;
  localparam int IDX_W      = $clog2(NUM_POINTS);
  localparam int EXT_W      = ((IDX_W > 7) ? IDX_W : 7) + 2;
  localparam int CNT_W      = $clog2(NUM_POINTS + 3);
  localparam int SWEEP_LEN  = NUM_POINTS + 2;
  localparam int GRID_W     = 48;
  localparam int FORCE_W    = 32;
  localparam int POS_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_LEVELS = 4;
  localparam int WORD_W     = GRID_W * NUM_LEVELS;
  localparam int BASE_W     = 52;
  localparam int MUL_LAT    = 5;
  localparam int NUM_COEFS  = 6;
  localparam int WIN_LEN    = 5;

  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [EXT_W-1:0]           ext_t;
  typedef logic signed [GRID_W-1:0]   grid_t;
  typedef grid_t [NUM_LEVELS-1:0]     word_t;

  localparam idx_t  IDX_LAST   = idx_t'(NUM_POINTS - 1);
  localparam idx_t  IDX_NM2    = idx_t'(NUM_POINTS - 2);
  localparam idx_t  IDX_BRIDGE = idx_t'(NUM_POINTS - 3);
  localparam ext_t  EXT_NPTS   = ext_t'(NUM_POINTS);
  localparam ext_t  EXT_LAST   = ext_t'(NUM_POINTS - 1);

  localparam grid_t MAX48 = 48'sh7FFF_FFFF_FFFF;
  localparam grid_t MIN48 = 48'sh8000_0000_0000;
  localparam logic signed [63:0] MAX48_EXT = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48_EXT = 64'shFFFF_8000_0000_0000;

  typedef enum logic [1:0] {
    CMD_STRIKE = 2'd0,
    CMD_FIRST  = 2'd1,
    CMD_FULL   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_WAVE  = 3'd0,
    REG_COEF_STIFF = 3'd1,
    REG_COEF_VEL   = 3'd2,
    REG_COEF_FREQ  = 3'd3,
    REG_COEF_HAM   = 3'd4,
    REG_COEF_BRG   = 3'd5,
    REG_CENTER     = 3'd6,
    REG_RADIUS     = 3'd7
  } cfg_reg_e;

  // level of each role in the current update
  typedef struct packed {
    logic [1:0] m1;
    logic [1:0] c0;
    logic [1:0] nw;
    logic [1:0] m2;
  } lvl_sel_t;

  // stencil stage result
  typedef struct packed {
    logic                     vld;
    idx_t                     j;
    word_t                    word;
    grid_t                    d2;
    grid_t                    f4;
    grid_t                    dv;
    grid_t                    d3;
    logic signed [BASE_W-1:0] base;
  } stage_t;

  // one point after the sum or force stages
  typedef struct packed {
    logic  vld;
    idx_t  j;
    word_t word;
    grid_t val;
  } point_t;

  function automatic grid_t sat48(input logic signed [63:0] v);
    grid_t r;
    if (v > MAX48_EXT) begin
      r = MAX48;
    end else if (v < MIN48_EXT) begin
      r = MIN48;
    end else begin
      r = v[GRID_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] ext64(input grid_t v);
    return 64'(v);
  endfunction

  function automatic grid_t lvl(input word_t w, input logic [1:0] k);
    return w[k];
  endfunction

endpackage

### rtl/sfd_intf.sv
// handshake channels of the grid stepper: request, response, register write
// depends on sfd_pkg
`timescale 1ns / 1ps

interface sfd_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          command;
  logic signed [sfd_pkg::FORCE_W-1:0]  hammer_force;
  logic signed [sfd_pkg::FORCE_W-1:0]  bridge_force;
  logic [sfd_pkg::POS_W-1:0]           element_index;

  modport source (output valid, command, hammer_force, bridge_force, element_index,
                  input ready);
  modport sink   (input valid, command, hammer_force, bridge_force, element_index,
                  output ready);
endinterface

interface sfd_out_if;
  logic                 valid;
  logic                 ready;
  sfd_pkg::grid_t       pickup_displacement;
  sfd_pkg::grid_t       pickup_velocity_diff;
  sfd_pkg::grid_t       bridge_curvature;
  sfd_pkg::grid_t       element_value;

  modport source (output valid, pickup_displacement, pickup_velocity_diff,
                  bridge_curvature, element_value, input ready);
  modport sink   (input valid, pickup_displacement, pickup_velocity_diff,
                  bridge_curvature, element_value, output ready);
endinterface

interface sfd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sfd_pkg::CFG_IDX_W-1:0]     index;
  logic [sfd_pkg::GRID_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sfd_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sfd_mulq.sv
// pipelined signed 48x48 multiply, rounded half away from zero, shifted, saturated
// built from four 24x24 partial products; depends on sfd_pkg
`timescale 1ns / 1ps

module sfd_mulq (
  input  logic           clk_i,
  input  sfd_pkg::grid_t a_i,
  input  sfd_pkg::grid_t b_i,
  input  logic           sh14_i,
  output sfd_pkg::grid_t p_o
);

  logic        neg1_q, neg2_q, neg3_q, neg4_q;
  logic        sh1_q, sh2_q, sh3_q, sh4_q;
  logic [47:0] ua_q, ub_q;
  logic [47:0] p00_q, p01_q, p10_q, p11_q;
  logic [48:0] mid_q;
  logic [95:0] hl_q;
  logic [95:0] prod_q;
  logic [95:0] prod_d;
  logic [95:0] rnd;
  logic [95:0] mag;
  sfd_pkg::grid_t p_q, p_d;

  // magnitudes
  always_ff @(posedge clk_i) begin
    neg1_q <= a_i[47] ^ b_i[47];
    sh1_q  <= sh14_i;
    ua_q   <= a_i[47] ? 48'(48'd0 - a_i) : a_i;
    ub_q   <= b_i[47] ? 48'(48'd0 - b_i) : b_i;
  end

  // partial products
  always_ff @(posedge clk_i) begin
    neg2_q <= neg1_q;
    sh2_q  <= sh1_q;
    p00_q  <= ua_q[23:0]  * ub_q[23:0];
    p01_q  <= ua_q[23:0]  * ub_q[47:24];
    p10_q  <= ua_q[47:24] * ub_q[23:0];
    p11_q  <= ua_q[47:24] * ub_q[47:24];
  end

  always_ff @(posedge clk_i) begin
    neg3_q <= neg2_q;
    sh3_q  <= sh2_q;
    mid_q  <= 49'(p01_q) + 49'(p10_q);
    hl_q   <= {p11_q, p00_q};
  end

  assign rnd    = sh3_q ? (96'd1 << 13) : (96'd1 << 45);
  assign prod_d = hl_q + (96'(mid_q) << 24) + rnd;

  always_ff @(posedge clk_i) begin
    neg4_q <= neg3_q;
    sh4_q  <= sh3_q;
    prod_q <= prod_d;
  end

  assign mag = sh4_q ? (prod_q >> 14) : (prod_q >> 46);

  always_comb begin
    if (neg4_q) begin
      if (mag > 96'h8000_0000_0000) begin
        p_d = sfd_pkg::MIN48;
      end else begin
        p_d = sfd_pkg::grid_t'(48'd0 - mag[47:0]);
      end
    end else begin
      if (mag > 96'h7FFF_FFFF_FFFF) begin
        p_d = sfd_pkg::MAX48;
      end else begin
        p_d = sfd_pkg::grid_t'(mag[47:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

### rtl/sfd_stencil.sv
// spatial and time differences of one grid point from a five word window
// registered output; depends on sfd_pkg
`timescale 1ns / 1ps

module sfd_stencil (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sfd_pkg::word_t      win_i [sfd_pkg::WIN_LEN],
  input  sfd_pkg::lvl_sel_t   sel_i,
  input  logic                vld_i,
  input  sfd_pkg::idx_t       j_i,
  output sfd_pkg::stage_t     sa_o
);

  logic signed [63:0] y0, y1, y2, y3, y4, n, m1, m2;
  sfd_pkg::stage_t sa_q, sa_d;

  always_comb begin
    y0 = sfd_pkg::ext64(sfd_pkg::lvl(win_i[0], sel_i.c0));
    y1 = sfd_pkg::ext64(sfd_pkg::lvl(win_i[1], sel_i.c0));
    y2 = sfd_pkg::ext64(sfd_pkg::lvl(win_i[2], sel_i.c0));
    y3 = sfd_pkg::ext64(sfd_pkg::lvl(win_i[3], sel_i.c0));
    y4 = sfd_pkg::ext64(sfd_pkg::lvl(win_i[4], sel_i.c0));
    n  = sfd_pkg::ext64(sfd_pkg::lvl(win_i[2], sel_i.nw));
    m1 = sfd_pkg::ext64(sfd_pkg::lvl(win_i[2], sel_i.m1));
    m2 = sfd_pkg::ext64(sfd_pkg::lvl(win_i[2], sel_i.m2));

    sa_d.vld  = vld_i;
    sa_d.j    = j_i;
    sa_d.word = win_i[2];
    sa_d.d2   = sfd_pkg::sat48(y3 - 64'sd2 * y2 + y1);
    sa_d.f4   = sfd_pkg::sat48(y4 - 64'sd4 * y3 + 64'sd6 * y2 - 64'sd4 * y1 + y0);
    sa_d.dv   = sfd_pkg::sat48(n - y2);
    sa_d.d3   = sfd_pkg::sat48(n - 64'sd3 * y2 + 64'sd3 * m1 - m2);
    sa_d.base = sfd_pkg::BASE_W'(64'sd2 * y2 - m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= '0;
    end else begin
      sa_q <= sa_d;
    end
  end

  assign sa_o = sa_q;

endmodule

### rtl/stiff_string_fd_step.sv
// Finite-difference stepper for a stiff, damped string. Each grid point is one 192-bit RAM word
// holding its four time levels, so a command sweeps the grid once, reading one word per cycle,
// and every command (strike, first step, full step, read) passes NUM_POINTS + 2 word reads
// through the stencil, five multiplier stages, sum, hammer and bridge/write-back stages
// before the response. After reset the RAM is cleared word by word,
// during which no request is taken; register writes are taken at any time.
// The next request is taken while a response still waits to be read.
// depends on sfd_pkg, sfd_intf, sfd_ram, sfd_mulq, sfd_stencil
`timescale 1ns / 1ps

module stiff_string_fd_step (
  input  logic  clk_i,
  input  logic  rst_ni,
  sfd_in_if.sink    req_i,
  sfd_out_if.source rsp_o,
  sfd_cfg_if.sink   cfg_i
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  sfd_pkg::grid_t             coef_q [sfd_pkg::NUM_COEFS];
  logic [sfd_pkg::POS_W-1:0]  center_q, radius_q;

  // command context
  sfd_pkg::cmd_e              cmd_q;
  logic [sfd_pkg::POS_W-1:0]  idx_q;
  logic [1:0]                 slot_q, base_q, tl_q, nslot_q;
  sfd_pkg::idx_t              c_q;
  sfd_pkg::ext_t              lo_q, hi_q;
  sfd_pkg::grid_t             h_q, bb_q;

  // sweep control
  logic [sfd_pkg::CNT_W-1:0]  rd_cnt_q;
  logic                       iss_vld_q;
  logic [sfd_pkg::CNT_W-1:0]  iss_k_q;
  logic                       cen_vld_q;
  sfd_pkg::idx_t              cen_j_q;
  sfd_pkg::idx_t              clr_cnt_q;
  logic [sfd_pkg::MUL_LAT-1:0] pre_q;

  sfd_pkg::word_t             win_q [sfd_pkg::WIN_LEN];
  sfd_pkg::stage_t            sa;
  sfd_pkg::stage_t            md_q [sfd_pkg::MUL_LAT];
  sfd_pkg::point_t            ss_q, ss_d, hs_q, hs_d, wb_q, wb_d;
  sfd_pkg::word_t             cap_c_q, cap_b_q, cap_e_q;

  logic                       out_vld_q;
  sfd_pkg::grid_t             out_pd_q, out_pvd_q, out_bc_q, out_ev_q;

  sfd_pkg::lvl_sel_t          sel;
  sfd_pkg::grid_t             ma [4];
  sfd_pkg::grid_t             mb [4];
  sfd_pkg::grid_t             mp [4];
  logic                       req_acc, issuing, stepping, full, out_load, interior;
  sfd_pkg::word_t             rdata;
  logic                       ram_we;
  sfd_pkg::idx_t              ram_waddr;
  sfd_pkg::word_t             ram_wdata;
  sfd_pkg::ext_t              c_ext, r_ext, lo_d, hi_d, hj_ext, wj_ext;
  logic [1:0]                 base_d, tl_d, nslot_d;
  logic signed [63:0]         sum;
  sfd_pkg::grid_t             lv0c, lv1c, lv0b, lv1b, lv3b, lv0e;

  assign req_acc     = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign stepping    = (cmd_q == sfd_pkg::CMD_FIRST) || (cmd_q == sfd_pkg::CMD_FULL);
  assign full        = (cmd_q == sfd_pkg::CMD_FULL);
  assign issuing     = (state_q == ST_SWEEP) &&
                       (rd_cnt_q < sfd_pkg::CNT_W'(sfd_pkg::SWEEP_LEN));

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sfd_pkg::NUM_COEFS; k++) begin
        coef_q[k] <= '0;
      end
      center_q <= sfd_pkg::POS_W'(5);
      radius_q <= sfd_pkg::POS_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (sfd_pkg::cfg_reg_e'(cfg_i.index))
        sfd_pkg::REG_CENTER: center_q <= cfg_i.data[sfd_pkg::POS_W-1:0];
        sfd_pkg::REG_RADIUS: radius_q <= cfg_i.data[sfd_pkg::POS_W-1:0];
        default:             coef_q[cfg_i.index] <= cfg_i.data;
      endcase
    end
  end

  // command decode at request time
  always_comb begin
    c_ext = sfd_pkg::ext_t'(center_q);
    if (c_ext >= sfd_pkg::EXT_NPTS) begin
      c_ext = sfd_pkg::EXT_LAST;
    end
    r_ext = sfd_pkg::ext_t'(radius_q);
    lo_d  = (c_ext >= r_ext) ? (c_ext - r_ext) : '0;
    hi_d  = c_ext + r_ext;
    if (hi_d > sfd_pkg::EXT_LAST) begin
      hi_d = sfd_pkg::EXT_LAST;
    end
    base_d  = 2'd0;
    tl_d    = 2'd2;
    nslot_d = slot_q;
    unique case (sfd_pkg::cmd_e'(req_i.command))
      sfd_pkg::CMD_STRIKE: begin
        tl_d    = 2'd1;
        nslot_d = 2'd0;
      end
      sfd_pkg::CMD_FIRST: begin
        nslot_d = 2'd1;
      end
      sfd_pkg::CMD_FULL: begin
        base_d  = slot_q;
        tl_d    = slot_q + 2'd2;
        nslot_d = slot_q + 2'd1;
      end
      sfd_pkg::CMD_READ: begin
        base_d  = slot_q;
        tl_d    = slot_q + 2'd2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q   <= sfd_pkg::cmd_e'(req_i.command);
      idx_q   <= req_i.element_index;
      base_q  <= base_d;
      tl_q    <= tl_d;
      nslot_q <= nslot_d;
      c_q     <= c_ext[sfd_pkg::IDX_W-1:0];
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
    if (pre_q[sfd_pkg::MUL_LAT-1]) begin
      h_q  <= mp[0];
      bb_q <= mp[1];
    end
  end

  // control state
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == sfd_pkg::IDX_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_acc) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (wb_q.vld && (wb_q.j == sfd_pkg::IDX_LAST)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      slot_q    <= 2'd0;
      clr_cnt_q <= '0;
      rd_cnt_q  <= '0;
      iss_vld_q <= 1'b0;
      iss_k_q   <= '0;
      cen_vld_q <= 1'b0;
      cen_j_q   <= '0;
      pre_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (req_acc) begin
        rd_cnt_q <= '0;
      end else if (issuing) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      iss_vld_q <= issuing;
      iss_k_q   <= rd_cnt_q;
      cen_vld_q <= iss_vld_q && (iss_k_q >= sfd_pkg::CNT_W'(2));
      cen_j_q   <= sfd_pkg::idx_t'(iss_k_q - sfd_pkg::CNT_W'(2));
      pre_q     <= {pre_q[sfd_pkg::MUL_LAT-2:0], req_acc};
      if (out_load) begin
        out_vld_q <= 1'b1;
        slot_q    <= nslot_q;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // grid memory, one word per point
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = wb_q.vld;
      ram_waddr = wb_q.j;
      ram_wdata = wb_q.word;
    end
  end

  sfd_ram #(
    .WIDTH (sfd_pkg::WORD_W),
    .DEPTH (sfd_pkg::NUM_POINTS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_cnt_q[sfd_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  // window of five neighboring points, center in the middle
  always_ff @(posedge clk_i) begin
    if (iss_vld_q) begin
      for (int k = 0; k < sfd_pkg::WIN_LEN - 1; k++) begin
        win_q[k] <= win_q[k+1];
      end
      win_q[sfd_pkg::WIN_LEN-1] <= rdata;
    end
  end

  assign sel.m1 = base_q;
  assign sel.c0 = base_q + 2'd1;
  assign sel.nw = base_q + 2'd2;
  assign sel.m2 = base_q + 2'd3;

  sfd_stencil u_stencil (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .win_i  (win_q),
    .sel_i  (sel),
    .vld_i  (cen_vld_q),
    .j_i    (cen_j_q),
    .sa_o   (sa)
  );

  // multiplier operands: hammer and bridge gains on the request cycle, stencil terms after
  always_comb begin
    ma[0] = req_acc ? coef_q[sfd_pkg::REG_COEF_HAM] : coef_q[sfd_pkg::REG_COEF_WAVE];
    mb[0] = req_acc ? sfd_pkg::grid_t'(req_i.hammer_force) : sa.d2;
    ma[1] = req_acc ? coef_q[sfd_pkg::REG_COEF_BRG]
                    : (full ? coef_q[sfd_pkg::REG_COEF_STIFF] : '0);
    mb[1] = req_acc ? sfd_pkg::grid_t'(req_i.bridge_force) : sa.f4;
    ma[2] = full ? coef_q[sfd_pkg::REG_COEF_VEL] : '0;
    mb[2] = sa.dv;
    ma[3] = full ? coef_q[sfd_pkg::REG_COEF_FREQ] : '0;
    mb[3] = sa.d3;
  end

  for (genvar g = 0; g < 4; g++) begin : g_mul
    sfd_mulq u_mulq (
      .clk_i  (clk_i),
      .a_i    (ma[g]),
      .b_i    (mb[g]),
      .sh14_i (req_acc),
      .p_o    (mp[g])
    );
  end

  // point context follows the multiplier latency
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < sfd_pkg::MUL_LAT; k++) begin
        md_q[k] <= '0;
      end
    end else begin
      md_q[0] <= sa;
      for (int k = 1; k < sfd_pkg::MUL_LAT; k++) begin
        md_q[k] <= md_q[k-1];
      end
    end
  end

  // sum of terms on interior points of step commands; other points pass their target level
  always_comb begin
    interior = 1'b0;
    if (cmd_q == sfd_pkg::CMD_FIRST) begin
      interior = (md_q[sfd_pkg::MUL_LAT-1].j >= sfd_pkg::idx_t'(1)) &&
                 (md_q[sfd_pkg::MUL_LAT-1].j <= sfd_pkg::IDX_NM2);
    end else if (full) begin
      interior = (md_q[sfd_pkg::MUL_LAT-1].j >= sfd_pkg::idx_t'(2)) &&
                 (md_q[sfd_pkg::MUL_LAT-1].j <= sfd_pkg::IDX_BRIDGE);
    end
    sum = sfd_pkg::ext64(mp[0]) + sfd_pkg::ext64(mp[1]) + sfd_pkg::ext64(mp[2])
        + sfd_pkg::ext64(mp[3]) + 64'(md_q[sfd_pkg::MUL_LAT-1].base);
    ss_d.vld  = md_q[sfd_pkg::MUL_LAT-1].vld;
    ss_d.j    = md_q[sfd_pkg::MUL_LAT-1].j;
    ss_d.word = md_q[sfd_pkg::MUL_LAT-1].word;
    ss_d.val  = (stepping && interior) ? sfd_pkg::sat48(sum)
                                       : sfd_pkg::lvl(md_q[sfd_pkg::MUL_LAT-1].word, tl_q);
  end

  // hammer force over the span, on every command but read
  always_comb begin
    hj_ext = sfd_pkg::ext_t'(ss_q.j);
    hs_d   = ss_q;
    if ((cmd_q != sfd_pkg::CMD_READ) && (hj_ext >= lo_q) && (hj_ext <= hi_q)) begin
      hs_d.val = sfd_pkg::sat48(sfd_pkg::ext64(ss_q.val) + sfd_pkg::ext64(h_q));
    end
  end

  // bridge force on full steps, then the new level goes back into the word
  always_comb begin
    wb_d = hs_q;
    if (full && (hs_q.j == sfd_pkg::IDX_BRIDGE)) begin
      wb_d.val = sfd_pkg::sat48(sfd_pkg::ext64(hs_q.val) + sfd_pkg::ext64(bb_q));
    end
    wb_d.word[tl_q] = wb_d.val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ss_q <= '0;
      hs_q <= '0;
      wb_q <= '0;
    end else begin
      ss_q <= ss_d;
      hs_q <= hs_d;
      wb_q <= wb_d;
    end
  end

  // keep the final words that feed the response
  assign wj_ext = sfd_pkg::ext_t'(wb_q.j);

  always_ff @(posedge clk_i) begin
    if (wb_q.vld) begin
      if (wb_q.j == c_q) begin
        cap_c_q <= wb_q.word;
      end
      if (wb_q.j == sfd_pkg::IDX_BRIDGE) begin
        cap_b_q <= wb_q.word;
      end
      if (wj_ext == sfd_pkg::ext_t'(idx_q)) begin
        cap_e_q <= wb_q.word;
      end
    end
  end

  // response
  always_comb begin
    lv0c = sfd_pkg::lvl(cap_c_q, nslot_q);
    lv1c = sfd_pkg::lvl(cap_c_q, nslot_q + 2'd1);
    lv0b = sfd_pkg::lvl(cap_b_q, nslot_q);
    lv1b = sfd_pkg::lvl(cap_b_q, nslot_q + 2'd1);
    lv3b = sfd_pkg::lvl(cap_b_q, nslot_q + 2'd3);
    lv0e = sfd_pkg::lvl(cap_e_q, nslot_q);
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pd_q  <= lv0c;
      out_pvd_q <= sfd_pkg::sat48(sfd_pkg::ext64(lv1c) - sfd_pkg::ext64(lv0c));
      out_bc_q  <= sfd_pkg::sat48(sfd_pkg::ext64(lv1b) - 64'sd2 * sfd_pkg::ext64(lv0b)
                                  + sfd_pkg::ext64(lv3b));
      if ((cmd_q == sfd_pkg::CMD_READ) &&
          (sfd_pkg::ext_t'(idx_q) < sfd_pkg::EXT_NPTS)) begin
        out_ev_q <= lv0e;
      end else begin
        out_ev_q <= '0;
      end
    end
  end

  assign rsp_o.valid                = out_vld_q;
  assign rsp_o.pickup_displacement  = out_pd_q;
  assign rsp_o.pickup_velocity_diff = out_pvd_q;
  assign rsp_o.bridge_curvature     = out_bc_q;
  assign rsp_o.element_value        = out_ev_q;

endmodule

### rtl/sfd_checker.sv
// port-level checks of the grid stepper, bound to the top level
// depends on assert_macros.svh and stiff_string_fd_step
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [47:0] rsp_pd_i,
  input logic [47:0] rsp_pvd_i,
  input logic [47:0] rsp_bc_i,
  input logic [47:0] rsp_ev_i
);

  `SFD_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "response dropped")
  `SFD_ASSERT_NEXT(a_rsp_stable, rsp_valid_i && !rsp_ready_i, $stable(rsp_pd_i) && $stable(rsp_pvd_i) && $stable(rsp_bc_i) && $stable(rsp_ev_i), "response changed while stalled")
  `SFD_ASSERT_NEXT(a_req_busy, req_valid_i && req_ready_i, !req_ready_i, "request taken while sweeping")
  `SFD_ASSERT_NEXT(a_no_early_rsp, req_valid_i && req_ready_i, !$rose(rsp_valid_i), "response before sweep")
  `SFD_ASSERT_NOW(a_rsp_idle, $rose(rsp_valid_i), req_ready_i, "new response without idle")

endmodule

bind stiff_string_fd_step sfd_checker u_sfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_pd_i    (rsp_o.pickup_displacement),
  .rsp_pvd_i   (rsp_o.pickup_velocity_diff),
  .rsp_bc_i    (rsp_o.bridge_curvature),
  .rsp_ev_i    (rsp_o.element_value)
);
